// ===== rtl/lprp_pkg.sv =====
package lprp_pkg;

	localparam int unsigned WIDE_BYTES   = 8;
	localparam int unsigned NARROW_BYTES = 4;
	localparam int unsigned LEN_W        = 8 * NARROW_BYTES;
	localparam int unsigned VALUE_W      = 8 * WIDE_BYTES;
	localparam int unsigned CNT_W        = $clog2(WIDE_BYTES);

	typedef enum logic [3:0] {
		FLD_AMOUNT     = 4'd0,
		FLD_SENDER_LEN = 4'd1,
		FLD_SENDER     = 4'd2,
		FLD_RECIP_LEN  = 4'd3,
		FLD_RECIP      = 4'd4,
		FLD_KEY_LEN    = 4'd5,
		FLD_KEY        = 4'd6,
		FLD_FEE        = 4'd7,
		FLD_SIG_LEN    = 4'd8,
		FLD_SIG        = 4'd9,
		FLD_EXCESS     = 4'd10
	} field_t;

	typedef enum logic [1:0] {
		ST_BUSY  = 2'd0,
		ST_VALID = 2'd1,
		ST_TRUNC = 2'd2,
		ST_TRAIL = 2'd3
	} status_t;

	typedef struct packed {
		field_t               field_code;
		logic [7:0]           byte_out;
		logic                 content_byte;
		logic                 value_ready;
		logic [VALUE_W-1:0]   field_value;
		logic                 record_end;
		status_t              status;
	} result_t;

endpackage

// ===== rtl/lprp_stream_if.sv =====
interface lprp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lprp_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  field_code;
	logic [7:0]  byte_out;
	logic        content_byte;
	logic        value_ready;
	logic [63:0] field_value;
	logic        record_end;
	logic [1:0]  status;

	modport source (
		output valid, output field_code, output byte_out, output content_byte,
		output value_ready, output field_value, output record_end, output status,
		input ready
	);
	modport sink (
		input valid, input field_code, input byte_out, input content_byte,
		input value_ready, input field_value, input record_end, input status,
		output ready
	);
endinterface

// ===== rtl/length_prefixed_record_parser_unit.sv =====
// An accepted byte waits in the input register until the result register can take it.
// Throughput: one byte per cycle unless the output stalls; the parser state is updated as
// the input register moves into the result register, so nothing waits on the previous byte.
// Reset (arst_n low, asynchronous): both register stages empty, parser back at the
// amount field with no bytes counted and no error held.
module length_prefixed_record_parser_unit (
	input logic clk,
	input logic arst_n,
	lprp_in_if.sink ingress,
	lprp_out_if.source egress
);
	import lprp_pkg::*;

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              valid_s2;
	result_t           res_s2;

	field_t            fidx_q, fidx_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [LEN_W-1:0]  rem_q, rem_d;
	logic [VALUE_W-1:0] acc_q, acc_d;
	logic              trail_q, trail_d;

	logic              out_free;
	logic              advance;
	result_t           res_d;
	logic [VALUE_W-1:0] merged;
	logic [LEN_W-1:0]  rem_dec;
	logic              wide;
	logic              num_done;

	assign out_free      = !valid_s2 || egress.ready;
	assign advance       = valid_s1 && out_free;
	assign ingress.ready = !valid_s1 || advance;

	always_comb begin
		fidx_d  = fidx_q;
		cnt_d   = cnt_q;
		rem_d   = rem_q;
		acc_d   = acc_q;
		trail_d = trail_q;
		merged  = acc_q;
		merged[{cnt_q, 3'b000} +: 8] = acc_q[{cnt_q, 3'b000} +: 8] | byte_s1;
		rem_dec = (rem_q != '0) ? rem_q - LEN_W'(1) : rem_q;
		wide    = (fidx_q == FLD_AMOUNT) || (fidx_q == FLD_FEE);
		num_done = wide ? (cnt_q == CNT_W'(WIDE_BYTES - 1))
		                : (cnt_q >= CNT_W'(NARROW_BYTES - 1));

		res_d.field_code   = fidx_q;
		res_d.byte_out     = byte_s1;
		res_d.content_byte = 1'b0;
		res_d.value_ready  = 1'b0;
		res_d.field_value  = '0;
		res_d.record_end   = last_s1;
		res_d.status       = ST_BUSY;

		if (fidx_q >= FLD_EXCESS) begin
			res_d.field_code = FLD_EXCESS;
			trail_d = 1'b1;
		end else begin
			case (fidx_q) inside
				FLD_SENDER, FLD_RECIP, FLD_KEY, FLD_SIG: begin
					res_d.content_byte = 1'b1;
					rem_d = rem_dec;
					if (rem_dec == '0)
						fidx_d = field_t'(fidx_q + 4'd1);
				end
				default: begin
					if (num_done) begin
						res_d.value_ready = 1'b1;
						res_d.field_value = merged;
						acc_d = '0;
						cnt_d = '0;
						if (wide) begin
							fidx_d = field_t'(fidx_q + 4'd1);
						end else if (merged[LEN_W-1:0] != '0) begin
							// non-empty length: step into its content field
							fidx_d = field_t'(fidx_q + 4'd1);
							rem_d  = merged[LEN_W-1:0];
						end else begin
							fidx_d = field_t'(fidx_q + 4'd2);
							rem_d  = '0;
						end
					end else begin
						acc_d = merged;
						cnt_d = cnt_q + CNT_W'(1);
					end
				end
			endcase
		end

		if (last_s1) begin
			if (trail_d)
				res_d.status = ST_TRAIL;
			else if (fidx_d >= FLD_EXCESS)
				res_d.status = ST_VALID;
			else
				res_d.status = ST_TRUNC;
			fidx_d  = FLD_AMOUNT;
			cnt_d   = '0;
			rem_d   = '0;
			acc_d   = '0;
			trail_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			fidx_q   <= FLD_AMOUNT;
			cnt_q    <= '0;
			rem_q    <= '0;
			acc_q    <= '0;
			trail_q  <= 1'b0;
		end else begin
			if (ingress.ready)
				valid_s1 <= ingress.valid;
			if (out_free)
				valid_s2 <= valid_s1;
			if (advance) begin
				fidx_q  <= fidx_d;
				cnt_q   <= cnt_d;
				rem_q   <= rem_d;
				acc_q   <= acc_d;
				trail_q <= trail_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ingress.ready && ingress.valid) begin
			byte_s1 <= ingress.data_byte;
			last_s1 <= ingress.last_byte;
		end
		if (advance)
			res_s2 <= res_d;
	end

	assign egress.valid        = valid_s2;
	assign egress.field_code   = res_s2.field_code;
	assign egress.byte_out     = res_s2.byte_out;
	assign egress.content_byte = res_s2.content_byte;
	assign egress.value_ready  = res_s2.value_ready;
	assign egress.field_value  = res_s2.field_value;
	assign egress.record_end   = res_s2.record_end;
	assign egress.status       = res_s2.status;

endmodule

// ===== rtl/lprp_checker.sv =====
module lprp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  field_code,
	input logic [7:0]  byte_out,
	input logic        content_byte,
	input logic        value_ready,
	input logic [63:0] field_value,
	input logic        record_end,
	input logic [1:0]  status
);
	import lprp_pkg::*;

	// a stalled result must hold
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(field_value)
			&& $stable(field_code) && $stable(status))
		else $error("result changed while stalled");

	a_status_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (record_end == (status != ST_BUSY)))
		else $error("status does not match record end");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !value_ready |-> field_value == '0)
		else $error("field value without completed number");

	a_content: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> content_byte == (field_code == FLD_SENDER || field_code == FLD_RECIP
			|| field_code == FLD_KEY || field_code == FLD_SIG))
		else $error("content flag disagrees with field");

	a_no_value_in_content: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (content_byte || field_code == FLD_EXCESS) |-> !value_ready)
		else $error("number completed on a content or excess byte");

endmodule

bind length_prefixed_record_parser_unit lprp_checker u_lprp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (egress.valid),
	.out_ready    (egress.ready),
	.field_code   (egress.field_code),
	.byte_out     (egress.byte_out),
	.content_byte (egress.content_byte),
	.value_ready  (egress.value_ready),
	.field_value  (egress.field_value),
	.record_end   (egress.record_end),
	.status       (egress.status)
);

// ===== verif/tb_length_prefixed_record_parser_unit.sv =====
module tb_length_prefixed_record_parser_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import lprp_pkg::*;

	localparam int RANDOM_BYTES = 1750;
	localparam int SHOWN_MISMATCHES = 10;
	localparam int STALL_CYCLES = 80;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} in_byte_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
		int         reps;
		logic       typed;
		result_t    res;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	lprp_in_if  in_ch ();
	lprp_out_if out_ch ();

	length_prefixed_record_parser_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.ingress (in_ch),
		.egress  (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser state as seen from outside
	field_t          cur_field = FLD_AMOUNT;
	logic [2:0]      num_count = '0;
	logic [31:0]     len_left  = '0;
	logic [63:0]     acc       = '0;
	logic            trailing  = 1'b0;

	result_t         expected_q[$];
	in_byte_t        record_q[$];
	plan_row_t       plan[$];

	int              tx_idle_pct = 23;
	int              rx_idle_pct = 49;
	logic            stall_req   = 1'b0;
	int              mismatches  = 0;

	function automatic result_t parse_byte(input logic [7:0] b, input logic lst);
		result_t     r;
		logic [3:0]  n;
		int unsigned width;
		logic [31:0] len;
		r = '0;
		r.field_code = cur_field;
		r.byte_out = b;
		r.record_end = lst;
		r.status = ST_BUSY;
		if (cur_field == FLD_EXCESS) begin
			trailing = 1'b1;
		end else if (cur_field inside {FLD_SENDER, FLD_RECIP, FLD_KEY, FLD_SIG}) begin
			r.content_byte = 1'b1;
			if (len_left != 0)
				len_left = len_left - 1;
			if (len_left == 0)
				cur_field = field_t'(cur_field + 4'd1);
		end else begin
			n = {1'b0, num_count};
			width = (cur_field == FLD_AMOUNT || cur_field == FLD_FEE)
				? WIDE_BYTES : NARROW_BYTES;
			acc |= 64'(b) << (8 * n);
			if (n + 1 >= width) begin
				r.value_ready = 1'b1;
				r.field_value = acc;
				acc = '0;
				num_count = '0;
				if (cur_field == FLD_AMOUNT || cur_field == FLD_FEE) begin
					cur_field = field_t'(cur_field + 4'd1);
				end else begin
					len = r.field_value[31:0];
					// an empty content field is skipped altogether
					if (len != 0) begin
						cur_field = field_t'(cur_field + 4'd1);
						len_left = len;
					end else begin
						cur_field = field_t'(cur_field + 4'd2);
						len_left = '0;
					end
				end
			end else begin
				num_count = 3'(n + 1);
			end
		end
		if (lst) begin
			if (trailing)
				r.status = ST_TRAIL;
			else if (cur_field == FLD_EXCESS)
				r.status = ST_VALID;
			else
				r.status = ST_TRUNC;
			cur_field = FLD_AMOUNT;
			num_count = '0;
			len_left = '0;
			acc = '0;
			trailing = 1'b0;
		end
		return r;
	endfunction

	function automatic void plan_byte(input logic [7:0] d, input logic l, input int reps);
		plan_row_t p;
		p.data = d;
		p.last = l;
		p.reps = reps;
		p.typed = 1'b0;
		p.res = '0;
		plan.push_back(p);
	endfunction

	function automatic void plan_known(input logic [7:0] d, input logic l, input field_t fc,
			input logic content, input logic rdy, input logic [63:0] v, input status_t st);
		plan_row_t p;
		p.data = d;
		p.last = l;
		p.reps = 1;
		p.typed = 1'b1;
		p.res.field_code = fc;
		p.res.byte_out = d;
		p.res.content_byte = content;
		p.res.value_ready = rdy;
		p.res.field_value = v;
		p.res.record_end = l;
		p.res.status = st;
		plan.push_back(p);
	endfunction

	function automatic void push_number(input logic [63:0] v, input int nb);
		for (int i = 0; i < nb; i++)
			record_q.push_back('{data: v[8*i +: 8], last: 1'b0});
	endfunction

	// mostly well-formed records; some cut short, some overlong, some plain noise
	function automatic void build_record();
		int          kind;
		int          cut;
		logic [31:0] len;
		logic        huge;
		kind = $urandom_range(99);
		huge = 1'b0;
		record_q.delete();
		if (kind >= 92) begin
			repeat ($urandom_range(1, 40))
				record_q.push_back('{data: 8'($urandom), last: 1'b0});
		end else begin
			push_number({$urandom, $urandom}, WIDE_BYTES);
			for (int f = 0; f < 4; f++) begin
				if (f == 3)
					push_number({$urandom, $urandom}, WIDE_BYTES);
				len = ($urandom_range(15) == 0) ? $urandom : $urandom_range(0, 6);
				huge |= (len > 12);
				push_number(64'(len), NARROW_BYTES);
				repeat ((len > 12) ? 12 : len)
					record_q.push_back('{data: 8'($urandom), last: 1'b0});
			end
			if (huge || (kind >= 70 && kind < 82)) begin
				cut = $urandom_range(0, record_q.size() - 2);
				record_q = record_q[0:cut];
			end else if (kind >= 82) begin
				repeat ($urandom_range(1, 3))
					record_q.push_back('{data: 8'($urandom), last: 1'b0});
			end
		end
		record_q[record_q.size() - 1].last = 1'b1;
	endfunction

	// valid stays high from one transfer to the next unless a gap is drawn
	task automatic send_byte(input logic [7:0] d, input logic l, input logic typed,
			input result_t res);
		result_t pred;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= d;
		in_ch.last_byte <= l;
		do
			@(posedge clk);
		while (!in_ch.ready);
		pred = parse_byte(d, l);
		expected_q.push_back(typed ? res : pred);
	endtask

	initial begin : stimulus
		int sent;
		int phase;
		int prev_phase;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.last_byte = 1'b0;
		sent = 0;
		prev_phase = -1;

		// lone last byte, then an all-ones amount, empty and one-byte fields,
		// an empty signature and bytes past the end of the record
		plan_known(8'h00, 1'b1, FLD_AMOUNT, 1'b0, 1'b0, 64'd0, ST_TRUNC);
		plan_byte(8'hFF, 1'b0, 7);
		plan_known(8'hFF, 1'b0, FLD_AMOUNT, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, ST_BUSY);
		plan_byte(8'h00, 1'b0, 3);
		plan_known(8'h00, 1'b0, FLD_SENDER_LEN, 1'b0, 1'b1, 64'd0, ST_BUSY);
		plan_byte(8'h01, 1'b0, 1);
		plan_byte(8'h00, 1'b0, 2);
		plan_known(8'h00, 1'b0, FLD_RECIP_LEN, 1'b0, 1'b1, 64'd1, ST_BUSY);
		plan_known(8'hA5, 1'b0, FLD_RECIP, 1'b1, 1'b0, 64'd0, ST_BUSY);
		plan_byte(8'h00, 1'b0, 4);
		plan_byte(8'h5A, 1'b0, 8);
		plan_byte(8'h00, 1'b0, 3);
		plan_known(8'h00, 1'b0, FLD_SIG_LEN, 1'b0, 1'b1, 64'd0, ST_BUSY);
		plan_known(8'h3C, 1'b0, FLD_EXCESS, 1'b0, 1'b0, 64'd0, ST_BUSY);
		plan_known(8'hC3, 1'b1, FLD_EXCESS, 1'b0, 1'b0, 64'd0, ST_TRAIL);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		foreach (plan[i])
			repeat (plan[i].reps)
				send_byte(plan[i].data, plan[i].last, plan[i].typed, plan[i].res);

		while (sent < RANDOM_BYTES) begin
			phase = sent * 3 / RANDOM_BYTES;
			if (phase != prev_phase) begin
				tx_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 49 : 0;
				rx_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 23 : 0;
				stall_req = 1'b1;
				prev_phase = phase;
			end
			build_record();
			foreach (record_q[i])
				send_byte(record_q[i].data, record_q[i].last, 1'b0, '0);
			sent += record_q.size();
		end
		in_ch.valid <= 1'b0;

		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// long hold-off so the pipeline fills and pushes back on the sender
	initial begin : receiver
		int hold;
		hold = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_req) begin
				stall_req = 1'b0;
				hold = STALL_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		logic    bad;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.field_code = field_t'(out_ch.field_code);
			got.byte_out = out_ch.byte_out;
			got.content_byte = out_ch.content_byte;
			got.value_ready = out_ch.value_ready;
			got.field_value = out_ch.field_value;
			got.record_end = out_ch.record_end;
			got.status = status_t'(out_ch.status);
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("unexpected transfer: field=%0d byte=%h value=%h status=%0d",
						got.field_code, got.byte_out, got.field_value, got.status);
			end else begin
				want = expected_q.pop_front();
				bad = (got.field_code !== want.field_code) ||
					(got.byte_out !== want.byte_out) ||
					(got.content_byte !== want.content_byte) ||
					(got.value_ready !== want.value_ready) ||
					(got.field_value !== want.field_value) ||
					(got.record_end !== want.record_end) ||
					(got.status !== want.status);
				if (bad) begin
					mismatches++;
					if (mismatches <= SHOWN_MISMATCHES) begin
						$display("mismatch exp: field=%0d byte=%h content=%b ready=%b ",
							want.field_code, want.byte_out, want.content_byte,
							want.value_ready, "value=%h end=%b status=%0d",
							want.field_value, want.record_end, want.status);
						$display("         got: field=%0d byte=%h content=%b ready=%b ",
							got.field_code, got.byte_out, got.content_byte,
							got.value_ready, "value=%h end=%b status=%0d",
							got.field_value, got.record_end, got.status);
					end
				end
			end
		end
	end

	initial begin : watchdog
		#3_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
